[sv/assert_macros.svh]
// Assertion macros used by float_to_trit_float_encoder, the RTL top of the trit-float encoder.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

[sv/ftf_pkg.sv]
// Package of the trit-float encoder: widths, constant tables and code helpers.
// No dependencies; used by ftf_trial_unit and float_to_trit_float_encoder.
package ftf_pkg;

   localparam int EXP_W    = 4;   // exponent index 0..8
   localparam int MANT_W   = 7;   // mantissa 0..80
   localparam int CODE_W   = 12;
   localparam int SIG_W    = 24;
   localparam int SCALE_W  = 13;
   localparam int SCALED_W = SIG_W + SCALE_W;  // significand times 6480
   localparam int SHIFT_W  = 6;
   localparam int COARSE_W = 21;  // scaled value shifted right by s-1
   localparam int QUOT_W   = 20;  // scaled value rounded to units of 2^s
   localparam int RECIP_W  = 20;
   localparam int PROD_W   = QUOT_W + RECIP_W;
   localparam int POW_W    = 13;
   localparam int QD_W     = MANT_W + POW_W;
   localparam int ERR_W    = 40;

   localparam logic [SCALE_W-1:0] SIG_SCALE = 13'd6480;
   localparam logic [EXP_W-1:0]   EXP_MAX   = 4'd8;
   localparam logic [MANT_W-1:0]  MANT_MAX  = 7'd80;
   localparam logic [CODE_W-1:0]  ZERO_CODE = 12'd973;
   localparam logic [CODE_W-1:0]  NAN_CODE  = 12'd0;
   localparam logic [7:0]         EXPF_INF  = 8'hFF;
   localparam logic [7:0]         EXPF_BIG  = 8'd134;
   localparam logic [7:0]         EXPF_TINY = 8'd113;
   localparam logic [7:0]         EXPF_BIAS = 8'd150;
   localparam logic [1:0]         TRIT_NEG  = 2'd0;
   localparam logic [1:0]         TRIT_POS  = 2'd2;

   // Result of a full sweep over the nine exponents.
   typedef struct packed {
      logic              done;
      logic [MANT_W-1:0] mant;
      logic [EXP_W-1:0]  exp_idx;
   } ftf_trial_type;

   function automatic logic [POW_W-1:0] pow3(input logic [EXP_W-1:0] k);
      logic [POW_W-1:0] r;
      unique case (k)
         4'd0:    r = 13'd1;
         4'd1:    r = 13'd3;
         4'd2:    r = 13'd9;
         4'd3:    r = 13'd27;
         4'd4:    r = 13'd81;
         4'd5:    r = 13'd243;
         4'd6:    r = 13'd729;
         4'd7:    r = 13'd2187;
         4'd8:    r = 13'd6561;
         default: r = 13'd0;
      endcase
      return r;
   endfunction

   // 81 * 3^k: a rounded quotient at or above this clamps to 80.
   function automatic logic [QUOT_W-1:0] clamp_limit(input logic [EXP_W-1:0] k);
      logic [QUOT_W-1:0] r;
      unique case (k)
         4'd0:    r = 20'd81;
         4'd1:    r = 20'd243;
         4'd2:    r = 20'd729;
         4'd3:    r = 20'd2187;
         4'd4:    r = 20'd6561;
         4'd5:    r = 20'd19683;
         4'd6:    r = 20'd59049;
         4'd7:    r = 20'd177147;
         4'd8:    r = 20'd531441;
         default: r = 20'd0;
      endcase
      return r;
   endfunction

   // ceil(2^L / 3^k) with 2^L >= 81 * 9^k: exact quotient for every value
   // below the clamp limit.
   function automatic logic [RECIP_W-1:0] recip(input logic [EXP_W-1:0] k);
      logic [RECIP_W-1:0] r;
      unique case (k)
         4'd0:    r = 20'd128;
         4'd1:    r = 20'd342;
         4'd2:    r = 20'd911;
         4'd3:    r = 20'd2428;
         4'd4:    r = 20'd12946;
         4'd5:    r = 20'd34522;
         4'd6:    r = 20'd92057;
         4'd7:    r = 20'd245483;
         4'd8:    r = 20'd654621;
         default: r = 20'd0;
      endcase
      return r;
   endfunction

   function automatic logic [SHIFT_W-1:0] recip_shift(input logic [EXP_W-1:0] k);
      logic [SHIFT_W-1:0] r;
      unique case (k)
         4'd0:    r = 6'd7;
         4'd1:    r = 6'd10;
         4'd2:    r = 6'd13;
         4'd3:    r = 6'd16;
         4'd4:    r = 6'd20;
         4'd5:    r = 6'd23;
         4'd6:    r = 6'd26;
         4'd7:    r = 6'd29;
         4'd8:    r = 6'd32;
         default: r = 6'd0;
      endcase
      return r;
   endfunction

   function automatic logic [CODE_W-1:0] make_code(input logic [1:0]        sign_code,
                                                   input logic [MANT_W-1:0] mant,
                                                   input logic [EXP_W-1:0]  k);
      return CODE_W'(sign_code) + CODE_W'(mant) * CODE_W'(3)
             + CODE_W'(k) * CODE_W'(243);
   endfunction

endpackage

[sv/float_to_trit_float_encoder.sv]
// Float32 to 7-trit code encoder with pair packing into 24-bit words.
// Depends on ftf_pkg, ftf_trial_unit and assert_macros.svh.
// A normal value passes unpack, align, nine trials, pipeline drain, pick and pair on its
// way to the result register; zero, NaN, infinite, large or tiny values go from unpack
// straight to pair. A new value is taken only once the sequencer is back in idle.
// Reset is synchronous and active high; it empties the pair holder and the result register.
`include "assert_macros.svh"

module float_to_trit_float_encoder import ftf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_value_bits,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [23:0] rsp_packed_bytes,
   output logic        rsp_ends_array
);

   // Sequencer states. UNPACK sorts out the special values and scales the
   // significand, PREP aligns it, SWEEP issues the nine exponent trials, WAIT
   // lets the trial pipeline drain and DONE pairs the code up.
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_UNPACK = 6'b000010,
      ST_PREP   = 6'b000100,
      ST_SWEEP  = 6'b001000,
      ST_WAIT   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [31:0]         value_ff, value_in;
   logic                last_ff, last_in;
   logic [SCALED_W-1:0] scaled_ff, scaled_in;
   logic [SHIFT_W-1:0]  shift_ff, shift_in;
   logic [COARSE_W-1:0] coarse_ff, coarse_in;
   logic [EXP_W-1:0]    k_ff, k_in;
   logic [CODE_W-1:0]   code_ff, code_in;
   logic [CODE_W-1:0]   held_code_ff, held_code_in;
   logic                held_valid_ff, held_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [23:0]         rsp_packed_ff, rsp_packed_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [7:0]          expf;
   logic [22:0]         frac;
   logic [1:0]          value_trit;
   logic [SCALED_W-1:0] coarse_wide;
   logic                out_free;
   logic                issue_valid;
   ftf_trial_type       trial_res;

   assign expf       = value_ff[30:23];
   assign frac       = value_ff[22:0];
   assign value_trit = value_ff[31] ? TRIT_NEG : TRIT_POS;

   // Dropping s-1 fraction bits here leaves just enough for the half-up
   // rounding at scale 2^s inside the trial unit.
   assign coarse_wide = scaled_ff >> (shift_ff - SHIFT_W'(1));

   // The result register frees up in the same cycle its beat is taken.
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign issue_valid = (state_ff == ST_SWEEP);

   ftf_trial_unit u_trial (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (issue_valid),
      .issue_k     (k_ff),
      .scaled      (scaled_ff),
      .coarse      (coarse_ff),
      .shift       (shift_ff),
      .result      (trial_res)
   );

   always_comb begin
      state_in      = state_ff;
      value_in      = value_ff;
      last_in       = last_ff;
      scaled_in     = scaled_ff;
      shift_in      = shift_ff;
      coarse_in     = coarse_ff;
      k_in          = k_ff;
      code_in       = code_ff;
      held_code_in  = held_code_ff;
      held_valid_in = held_valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_packed_in = rsp_packed_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               value_in = req_value_bits;
               last_in  = req_is_last;
               state_in = ST_UNPACK;
            end
         end
         ST_UNPACK: begin
            // NaN is checked first since it shares the all-ones exponent with
            // infinity; infinity falls into the saturating case below.
            scaled_in = SCALED_W'({1'b1, frac}) * SCALED_W'(SIG_SCALE);
            shift_in  = SHIFT_W'(EXPF_BIAS - expf);
            priority if ((expf == EXPF_INF) && (frac != '0)) begin
               code_in  = NAN_CODE;
               state_in = ST_DONE;
            end else if ((expf == '0) && (frac == '0)) begin
               code_in  = ZERO_CODE;
               state_in = ST_DONE;
            end else if (expf >= EXPF_BIG) begin
               code_in  = make_code(value_trit, MANT_MAX, EXP_MAX);
               state_in = ST_DONE;
            end else if (expf < EXPF_TINY) begin
               // Every mantissa rounds to zero, so the lowest exponent wins.
               code_in  = make_code(value_trit, '0, '0);
               state_in = ST_DONE;
            end else begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            coarse_in = coarse_wide[COARSE_W-1:0];
            k_in      = '0;
            state_in  = ST_SWEEP;
         end
         ST_SWEEP: begin
            k_in = k_ff + EXP_W'(1);
            if (k_ff == EXP_MAX) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (trial_res.done) begin
               code_in  = make_code(value_trit, trial_res.mant, trial_res.exp_idx);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (held_valid_ff || last_ff) begin
               // A pair is complete, or the array ends on an unpaired code,
               // which is then padded with an all-zero upper half.
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_packed_in = held_valid_ff ? {code_ff, held_code_ff}
                                                : {{CODE_W{1'b0}}, code_ff};
                  rsp_last_in   = last_ff;
                  held_code_in  = '0;
                  held_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else begin
               held_code_in  = code_ff;
               held_valid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_code_ff  <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_code_ff  <= held_code_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      last_ff       <= last_in;
      scaled_ff     <= scaled_in;
      shift_ff      <= shift_in;
      coarse_ff     <= coarse_in;
      k_ff          <= k_in;
      code_ff       <= code_in;
      rsp_packed_ff <= rsp_packed_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_packed_bytes = rsp_packed_ff;
   assign rsp_ends_array   = rsp_last_ff;

   // The trial unit only reports a finished sweep while the sequencer waits for it.
   `ASSERT_IMPLIES(a_done_in_wait, clock, reset, trial_res.done, state_ff == ST_WAIT)
   // The sweep never issues an exponent index beyond the last one.
   `ASSERT_IMPLIES(a_sweep_range, clock, reset, state_ff == ST_SWEEP, k_ff <= EXP_MAX)
   // A new result beat is only ever loaded from the pairing state.
   `ASSERT_IMPLIES(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)
   // An empty pair holder always holds all-zero bits.
   `ASSERT_IMPLIES(a_held_clear, clock, reset, !held_valid_ff, held_code_ff == '0)

endmodule

[sv/ftf_trial_unit.sv]
// Pipelined exponent trial unit: rounds, clamps and scores one exponent per cycle.
// Depends on ftf_pkg.
module ftf_trial_unit import ftf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                issue_valid,
   input  logic [EXP_W-1:0]    issue_k,
   input  logic [SCALED_W-1:0] scaled,
   input  logic [COARSE_W-1:0] coarse,
   input  logic [SHIFT_W-1:0]  shift,
   output ftf_trial_type       result
);

   logic [COARSE_W-1:0] sum;
   logic [QUOT_W-1:0]   w;
   logic                over;

   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff, done_ff;
   logic [EXP_W-1:0]    s1_k_ff, s2_k_ff, s3_k_ff, best_k_ff;
   logic [QUOT_W-1:0]   s1_w_ff;
   logic                s1_over_ff, s2_over_ff;
   logic [PROD_W-1:0]   s2_prod_ff, s2_prod_in;
   logic [PROD_W-1:0]   prod_shifted;
   logic [MANT_W-1:0]   q;
   logic [MANT_W-1:0]   s3_q_ff, best_q_ff;
   logic [QD_W-1:0]     s3_qd_ff, s3_qd_in;
   logic [ERR_W-1:0]    approx, target, err;
   logic [ERR_W-1:0]    least_err_ff;
   logic                take;

   // Round half up at scale 2^s, then test against the clamp limit.
   assign sum  = coarse + COARSE_W'(pow3(issue_k));
   assign w    = sum[COARSE_W-1:1];
   assign over = (w >= clamp_limit(issue_k));

   assign s2_prod_in = PROD_W'(s1_w_ff) * PROD_W'(recip(s1_k_ff));

   assign prod_shifted = s2_prod_ff >> recip_shift(s2_k_ff);
   assign q            = s2_over_ff ? MANT_MAX : prod_shifted[MANT_W-1:0];
   assign s3_qd_in     = QD_W'(q) * QD_W'(pow3(s2_k_ff));

   // The product never reaches 2^39, so the shifted value fits the error width.
   assign approx = ERR_W'(s3_qd_ff) << shift;
   assign target = ERR_W'(scaled);
   assign err    = (target >= approx) ? (target - approx) : (approx - target);
   assign take   = s3_valid_ff && ((s3_k_ff == '0) || (err < least_err_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= issue_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         done_ff     <= s3_valid_ff && (s3_k_ff == EXP_MAX);
      end
   end

   always_ff @(posedge clock) begin
      s1_k_ff    <= issue_k;
      s1_w_ff    <= w;
      s1_over_ff <= over;
      s2_k_ff    <= s1_k_ff;
      s2_over_ff <= s1_over_ff;
      s2_prod_ff <= s2_prod_in;
      s3_k_ff    <= s2_k_ff;
      s3_q_ff    <= q;
      s3_qd_ff   <= s3_qd_in;
      if (take) begin
         least_err_ff <= err;
         best_q_ff    <= s3_q_ff;
         best_k_ff    <= s3_k_ff;
      end
   end

   assign result.done    = done_ff;
   assign result.mant    = best_q_ff;
   assign result.exp_idx = best_k_ff;

endmodule
